// ===== rtl/tvnf_pkg.sv =====
// Shared types and constants for the text visualize and line number filter.
`default_nettype none
package tvnf_pkg;

  localparam logic [3:0] MODE_PASS        = 4'd0;
  localparam logic [3:0] MODE_VIS_DOLLAR  = 4'd1;
  localparam logic [3:0] MODE_NUM_ALL     = 4'd2;
  localparam logic [3:0] MODE_NUM_NONBLANK = 4'd3;
  localparam logic [3:0] MODE_SQUEEZE     = 4'd4;
  localparam logic [3:0] MODE_VIS_TAB     = 4'd5;
  localparam logic [3:0] MODE_VIS         = 4'd6;
  localparam logic [3:0] MODE_TAB_ONLY    = 4'd7;
  localparam logic [3:0] MODE_DOLLAR_ONLY = 4'd8;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_QUEST  = 8'd63;
  localparam logic [7:0] CH_I      = 8'd73;
  localparam logic [7:0] CH_M      = 8'd77;
  localparam logic [7:0] CH_CARET  = 8'd94;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_HIGH   = 8'd160;
  localparam logic [7:0] CH_FF     = 8'd255;

  localparam logic [23:0] BCD_ONE = 24'h000001;
  localparam logic [23:0] BCD_MAX = 24'h999999;

  localparam int JOB_BYTES = 8;

  // Output bytes caused by one input item, delivered from index 0 up.
  typedef struct packed {
    logic [3:0]                     count;
    logic [JOB_BYTES-1:0][7:0]      data;
  } job_t;

endpackage
`default_nettype wire

// ===== rtl/tvnf_front.sv =====
// Front part: accepts input bytes, tracks line state and builds the output bytes of each item.
`default_nettype none
module tvnf_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,     // in_byte
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [3:0]    cfg_data,    // mode
  input  wire logic          q_full,
  output logic               push,
  output tvnf_pkg::job_t     job
);
  import tvnf_pkg::*;

  logic [3:0]  mode;
  logic [23:0] line_bcd;
  logic [23:0] line_bcd_next;
  logic        at_line_start;
  logic [1:0]  newline_run;

  logic        accept;
  logic        is_nl;
  logic        is_tab;
  logic        numbered;
  logic [2:0]  vis_cnt;
  logic [3:0][7:0] vis;
  logic [6:0][7:0] pfx;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign is_nl     = (s_tdata == CH_NL);
  assign is_tab    = (s_tdata == CH_TAB);
  assign push      = accept && (job.count != 4'd0);

  always_comb begin
    vis     = '0;
    vis_cnt = 3'd1;
    vis[0]  = s_tdata;
    if (is_tab || is_nl) begin
      vis_cnt = 3'd1;
    end else if (s_tdata < 8'd32) begin
      vis_cnt = 3'd2;
      vis[0]  = CH_CARET;
      vis[1]  = s_tdata + 8'd64;
    end else if (s_tdata == CH_DEL) begin
      vis_cnt = 3'd2;
      vis[0]  = CH_CARET;
      vis[1]  = CH_QUEST;
    end else if (s_tdata[7] && (s_tdata < CH_HIGH)) begin
      vis_cnt = 3'd4;
      vis[0]  = CH_M;
      vis[1]  = CH_DASH;
      vis[2]  = CH_CARET;
      vis[3]  = s_tdata - 8'd64;
    end else if (s_tdata == CH_FF) begin
      vis_cnt = 3'd4;
      vis[0]  = CH_M;
      vis[1]  = CH_DASH;
      vis[2]  = CH_CARET;
      vis[3]  = CH_QUEST;
    end else if (s_tdata[7]) begin
      vis_cnt = 3'd3;
      vis[0]  = CH_M;
      vis[1]  = CH_DASH;
      vis[2]  = s_tdata - 8'd128;
    end
  end

  always_comb begin
    logic       lead;
    logic [3:0] d;
    lead = 1'b1;
    pfx  = '0;
    for (int k = 5; k >= 0; k--) begin
      d = line_bcd[4*k +: 4];
      if ((d != 4'd0) || (k == 0)) begin
        lead = 1'b0;
      end
      pfx[5-k] = lead ? CH_SPACE : (CH_ZERO + {4'd0, d});
    end
    pfx[6] = CH_TAB;
  end

  always_comb begin
    logic       carry;
    logic [4:0] d;
    carry         = 1'b1;
    line_bcd_next = '0;
    for (int k = 0; k < 6; k++) begin
      d = {1'b0, line_bcd[4*k +: 4]} + {4'd0, carry};
      carry = 1'b0;
      if (d > 5'd9) begin
        d     = 5'd0;
        carry = 1'b1;
      end
      line_bcd_next[4*k +: 4] = d[3:0];
    end
    if (line_bcd == BCD_MAX) begin
      line_bcd_next = BCD_MAX;
    end
  end

  always_comb begin
    job         = '0;
    job.count   = 4'd1;
    job.data[0] = s_tdata;
    numbered    = 1'b0;
    case (mode)
      MODE_VIS_DOLLAR: begin
        if (is_nl) begin
          job.count   = 4'd2;
          job.data[0] = CH_DOLLAR;
          job.data[1] = CH_NL;
        end else begin
          job.count        = {1'b0, vis_cnt};
          job.data[3:0]    = vis;
        end
      end
      MODE_NUM_ALL: begin
        numbered = at_line_start;
      end
      MODE_NUM_NONBLANK: begin
        numbered = at_line_start && !is_nl;
      end
      MODE_SQUEEZE: begin
        if (is_nl && (newline_run == 2'd2)) begin
          job.count = 4'd0;
        end
      end
      MODE_VIS_TAB: begin
        if (is_tab) begin
          job.count   = 4'd2;
          job.data[0] = CH_CARET;
          job.data[1] = CH_I;
        end else begin
          job.count     = {1'b0, vis_cnt};
          job.data[3:0] = vis;
        end
      end
      MODE_VIS: begin
        job.count     = {1'b0, vis_cnt};
        job.data[3:0] = vis;
      end
      MODE_TAB_ONLY: begin
        if (is_tab) begin
          job.count   = 4'd2;
          job.data[0] = CH_CARET;
          job.data[1] = CH_I;
        end
      end
      MODE_DOLLAR_ONLY: begin
        if (is_nl) begin
          job.count   = 4'd2;
          job.data[0] = CH_DOLLAR;
          job.data[1] = CH_NL;
        end
      end
      default: begin
        job.count = 4'd1;
      end
    endcase
    if (numbered) begin
      job.count     = 4'd8;
      job.data[6:0] = pfx;
      job.data[7]   = s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PASS;
      line_bcd      <= BCD_ONE;
      at_line_start <= 1'b1;
      newline_run   <= 2'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      if (accept) begin
        if (numbered) begin
          line_bcd <= line_bcd_next;
        end
        at_line_start <= is_nl;
        if (!is_nl) begin
          newline_run <= 2'd0;
        end else if (newline_run != 2'd2) begin
          newline_run <= newline_run + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tvnf_queue.sv =====
// Short queue of built items between the front and back parts.
`default_nettype none
module tvnf_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tvnf_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output tvnf_pkg::job_t     head_job
);
  import tvnf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tvnf_back.sv =====
// Back part: sends the bytes of each queued item one per cycle while m_tready allows, through an output register.
`default_nettype none
module tvnf_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire tvnf_pkg::job_t head_job,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,     // out_byte
  output logic               m_tlast      // last_of_run
);
  import tvnf_pkg::*;

  logic [2:0] idx;
  logic       load;
  logic       take;
  logic       is_last;

  assign load    = !m_tvalid || m_tready;
  assign take    = load && head_valid;
  assign is_last = ({1'b0, idx} == (head_job.count - 4'd1));
  assign pop     = take && is_last;

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= head_job.data[idx];
      m_tlast <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        m_tvalid <= head_valid;
      end
      if (take) begin
        idx <= is_last ? 3'd0 : idx + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/text_visualize_number_filter.sv =====
// Top level of the text visualize and line number filter.
// The block takes one text byte per cycle while its internal queue has room
// and delivers zero to eight output bytes for it, one byte per cycle on the
// output while m_tready is high, so the sustained rate is one input byte per
// cycle when each byte yields one output byte and otherwise is set by the
// number of output bytes per item. The first output byte of an item passes
// through the queue storage and then the output register before it is valid.
// The mode register is written through the configuration channel, which is
// always ready; write it only while the block is idle.
`default_nettype none
module text_visualize_number_filter #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,     // in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,     // out_byte
  output logic             m_tlast,     // last_of_run
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data     // mode
);
  import tvnf_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_head_valid;
  job_t q_push_job;
  job_t q_head_job;

  tvnf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (q_push),
    .job       (q_push_job)
  );

  tvnf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  tvnf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire
